// ===== sv/lflm_pkg.sv =====
package lflm_pkg;

  // Field widths of the request and result items.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned BLK_W = 10;
  localparam int unsigned CNT_W = 11;

  // Default pool size.
  localparam int unsigned NUM_BLOCKS_DEF = 1024;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_PUSH       = 2'd0;
  localparam logic [OP_W-1:0] OP_POP        = 2'd1;
  localparam logic [OP_W-1:0] OP_PUSH_RANGE = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_RANGE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new request
    logic step;    // follow one link of the chain
    logic finish;  // commit the request and write the result item
  } lflm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;     // request is a push or push range
    logic list_empty;  // top pointer holds the null marker
    logic walk_done;   // chain walk has reached its end
    logic slot_free;   // result register can take a new item
  } lflm_stat_t;

endpackage

// ===== sv/lflm_if.sv =====
// Request channel: one item per free-list operation.
interface lflm_req_if;
  logic                        valid;
  logic                        ready;
  logic [lflm_pkg::OP_W-1:0]   opcode;
  logic [lflm_pkg::BLK_W-1:0]  block;
  logic [lflm_pkg::BLK_W-1:0]  last_block;
  logic [lflm_pkg::CNT_W-1:0]  count;

  modport source (output valid, opcode, block, last_block, count, input ready);
  modport sink   (input valid, opcode, block, last_block, count, output ready);
endinterface

// Result channel: one item per request.
interface lflm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [lflm_pkg::BLK_W-1:0]  first_out;
  logic [lflm_pkg::BLK_W-1:0]  last_out;
  logic [lflm_pkg::CNT_W-1:0]  moved;
  logic [lflm_pkg::CNT_W-1:0]  free_count;
  logic                        list_empty;

  modport source (output valid, status, first_out, last_out, moved, free_count, list_empty,
                  input ready);
  modport sink   (input valid, status, first_out, last_out, moved, free_count, list_empty,
                  output ready);
endinterface

// ===== sv/lflm_ctrl.sv =====
module lflm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lflm_pkg::lflm_stat_t stat,
  output lflm_pkg::lflm_cmd_t  cmd
);
  import lflm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   done;

  // A request is over once it is a push, finds the list empty, or its walk has ended.
  assign done = stat.is_push || stat.list_empty || stat.walk_done;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!done) begin
          cmd.step = 1'b1;
        end else if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/lflm_datapath.sv =====
module lflm_datapath #(
  parameter int unsigned NUM_BLOCKS = lflm_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lflm_pkg::lflm_cmd_t         cmd,
  output lflm_pkg::lflm_stat_t        stat,
  input  logic [lflm_pkg::OP_W-1:0]   in_opcode,
  input  logic [lflm_pkg::BLK_W-1:0]  in_block,
  input  logic [lflm_pkg::BLK_W-1:0]  in_last_block,
  input  logic [lflm_pkg::CNT_W-1:0]  in_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [lflm_pkg::BLK_W-1:0]  out_first_out,
  output logic [lflm_pkg::BLK_W-1:0]  out_last_out,
  output logic [lflm_pkg::CNT_W-1:0]  out_moved,
  output logic [lflm_pkg::CNT_W-1:0]  out_free_count,
  output logic                        out_list_empty
);
  import lflm_pkg::*;

  localparam int unsigned PW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam logic [PW-1:0] NULL_MARK = PW'(NUM_BLOCKS);
  localparam logic [SW-1:0] NUM_S = SW'(NUM_BLOCKS);

  // Request registers.
  logic [OP_W-1:0]  op_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] last_r;
  logic [CNT_W-1:0] cnt_r;

  // List state and walk registers.
  logic [PW-1:0]    top_r;
  logic [PW-1:0]    total_r;
  logic [PW-1:0]    cur_r;
  logic [CNT_W-1:0] taken_r;
  logic [PW-1:0]    rd_data_r;

  // Link store.
  logic [PW-1:0]    link_mem [NUM_BLOCKS];

  // Result register.
  logic             out_valid_r;
  logic             out_status_r;
  logic [BLK_W-1:0] out_first_r;
  logic [BLK_W-1:0] out_last_r;
  logic [CNT_W-1:0] out_moved_r;
  logic [CNT_W-1:0] out_free_r;
  logic             out_empty_r;

  logic             is_push;
  logic             push_ok;
  logic             top_empty;
  logic             popped;
  logic [CNT_W-1:0] want;
  logic [CNT_W-1:0] add_n;
  logic [SW-1:0]    sum;
  logic [PW-1:0]    total_add;
  logic [PW-1:0]    total_sub;
  logic [PW-1:0]    top_fin;
  logic [PW-1:0]    total_fin;
  logic [PW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PW-1:0]    wr_data;

  // Decode of the held request.
  always_comb begin
    is_push   = (op_r == OP_PUSH) || (op_r == OP_PUSH_RANGE);
    push_ok   = (SW'(blk_r) < NUM_S) &&
                ((op_r == OP_PUSH) || (SW'(last_r) < NUM_S));
    top_empty = (top_r >= NULL_MARK);
    popped    = !is_push && !top_empty;
    want      = ((op_r == OP_POP) || (cnt_r == '0)) ? CNT_W'(1) : cnt_r;
  end

  // Status toward the controller.
  always_comb begin
    stat.is_push    = is_push;
    stat.list_empty = top_empty;
    stat.walk_done  = (taken_r >= want) || (rd_data_r >= NULL_MARK);
    stat.slot_free  = !out_valid_r || out_ready;
  end

  // Saturating free count updates.
  always_comb begin
    add_n     = (op_r == OP_PUSH) ? CNT_W'(1) : cnt_r;
    sum       = SW'(total_r) + SW'(add_n);
    total_add = (sum > NUM_S) ? NULL_MARK : PW'(sum);
    total_sub = (SW'(taken_r) > SW'(total_r)) ? '0 : PW'(SW'(total_r) - SW'(taken_r));
  end

  // List state after the request commits.
  always_comb begin
    top_fin   = top_r;
    total_fin = total_r;
    priority if (is_push) begin
      if (push_ok) begin
        top_fin   = PW'(blk_r);
        total_fin = total_add;
      end
    end else if (!top_empty) begin
      // The link read at the last block of the walk is the new top.
      top_fin   = rd_data_r;
      total_fin = total_sub;
    end
  end

  // Link store write: pushes link to the old top, pop range ends its chain with null.
  always_comb begin
    wr_en   = cmd.finish && ((is_push && push_ok) || (popped && (op_r == OP_POP_RANGE)));
    wr_data = is_push ? top_r : NULL_MARK;
    unique case (op_r)
      OP_PUSH:       wr_addr = AW'(blk_r);
      OP_PUSH_RANGE: wr_addr = AW'(last_r);
      default:       wr_addr = AW'(cur_r);
    endcase
  end

  // The read address follows the next walk position, so rd_data_r holds the link of the current walk position.
  always_comb begin
    priority if (cmd.load) begin
      rd_addr = top_r;
    end else if (cmd.step) begin
      rd_addr = rd_data_r;
    end else begin
      rd_addr = cur_r;
    end
  end

  // Link store ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_addr < NULL_MARK) begin
      rd_data_r <= link_mem[AW'(rd_addr)];
    end else begin
      rd_data_r <= NULL_MARK;
    end
  end

  // Request capture and chain walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      blk_r   <= in_block;
      last_r  <= in_last_block;
      cnt_r   <= in_count;
      cur_r   <= top_r;
      taken_r <= CNT_W'(1);
    end else if (cmd.step) begin
      cur_r   <= rd_data_r;
      taken_r <= taken_r + CNT_W'(1);
    end
  end

  // Top pointer and free count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= NULL_MARK;
      total_r <= '0;
    end else if (cmd.finish) begin
      top_r   <= top_fin;
      total_r <= total_fin;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= !is_push && top_empty;
      out_first_r  <= popped ? BLK_W'(top_r) : '0;
      out_last_r   <= popped ? BLK_W'(cur_r) : '0;
      out_moved_r  <= popped ? taken_r : '0;
      out_free_r   <= CNT_W'(total_fin);
      out_empty_r  <= (top_fin >= NULL_MARK);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_first_out  = out_first_r;
  assign out_last_out   = out_last_r;
  assign out_moved      = out_moved_r;
  assign out_free_count = out_free_r;
  assign out_list_empty = out_empty_r;

endmodule

// ===== sv/linked_free_list_manager.sv =====
// Push, push range and pop: the item is latched, then committed into the result register.
// Pop range: the chain is walked from the top before the commit (no walk on an empty list), one link
// per cycle through the single read port of the link store.
// A new item is taken only after the last one has been committed;
// a result item still waiting on out_ch.ready holds the commit until it is taken.
// Reset (synchronous, active low) empties the list and zeroes the count; links are kept.
module linked_free_list_manager #(
  parameter int unsigned NUM_BLOCKS = lflm_pkg::NUM_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lflm_req_if.sink   in_ch,
  lflm_rsp_if.source out_ch
);
  import lflm_pkg::*;

  lflm_cmd_t  cmd;
  lflm_stat_t stat;

  // Sequencer for one request at a time.
  lflm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // List state, link store and result register.
  lflm_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_block       (in_ch.block),
    .in_last_block  (in_ch.last_block),
    .in_count       (in_ch.count),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_first_out  (out_ch.first_out),
    .out_last_out   (out_ch.last_out),
    .out_moved      (out_ch.moved),
    .out_free_count (out_ch.free_count),
    .out_list_empty (out_ch.list_empty)
  );

  // A result is only committed when the result register can take it.
  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result committed while the result register was full");

  // A committed result shows up on the output next cycle.
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("committed result not presented");

  // The block is busy right after taking an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while a request is in progress");

  // A pop that found the list empty moves nothing and leaves it empty.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> ((out_ch.moved == '0) && out_ch.list_empty))
    else $error("empty pop reported moved blocks");

endmodule

// ===== tb/lflm_checker.sv =====
`timescale 1ns / 100ps

module lflm_checker #(
  parameter int unsigned NUM_BLOCKS = lflm_pkg::NUM_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lflm_req_if         req,
  lflm_rsp_if         rsp,
  output int unsigned errors,
  output int unsigned replies_owed
);
  import lflm_pkg::*;

  typedef logic [CNT_W-1:0] ptr_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] first_out;
    logic [BLK_W-1:0] last_out;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] free_count;
    logic             list_empty;
  } list_reply_t;

  localparam ptr_t NULL_MARK = ptr_t'(NUM_BLOCKS);

  // Shadow copy of the free list: top pointer, free count and next links.
  ptr_t        top_ptr;
  ptr_t        free_total;
  ptr_t        next_of [NUM_BLOCKS];
  list_reply_t list_replies [$];

  // A link past the end of the pool reads as the null marker.
  function automatic ptr_t follow(ptr_t idx);
    if (idx >= NULL_MARK) return NULL_MARK;
    return next_of[idx[BLK_W-1:0]];
  endfunction

  // The free count saturates at the pool size going up and at zero going down.
  function automatic void grow_total(int unsigned n);
    int unsigned sum;
    sum = free_total + n;
    free_total = (sum > NUM_BLOCKS) ? ptr_t'(NUM_BLOCKS) : ptr_t'(sum);
  endfunction

  function automatic void shrink_total(int unsigned n);
    free_total = (n > free_total) ? ptr_t'(0) : ptr_t'(free_total - n);
  endfunction

  // Applies one request to the shadow list and returns the result item it owes.
  function automatic list_reply_t apply_list_op(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk,
                                                logic [BLK_W-1:0] last,
                                                logic [CNT_W-1:0] cnt);
    list_reply_t r;
    int unsigned want;
    int unsigned taken;
    ptr_t        cur;
    ptr_t        nxt;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (blk < NUM_BLOCKS) begin
          next_of[blk] = top_ptr;
          top_ptr = ptr_t'(blk);
          grow_total(1);
        end
      end
      OP_PUSH_RANGE: begin
        // Only the tail link is written; the inner links are already in place.
        if (blk < NUM_BLOCKS && last < NUM_BLOCKS) begin
          next_of[last] = top_ptr;
          top_ptr = ptr_t'(blk);
          grow_total(cnt);
        end
      end
      OP_POP: begin
        if (top_ptr >= NULL_MARK) begin
          r.status = 1'b1;
        end else begin
          r.first_out = top_ptr[BLK_W-1:0];
          r.last_out = top_ptr[BLK_W-1:0];
          r.moved = ptr_t'(1);
          top_ptr = follow(top_ptr);
          shrink_total(1);
        end
      end
      OP_POP_RANGE: begin
        if (top_ptr >= NULL_MARK) begin
          r.status = 1'b1;
        end else begin
          // A request for zero blocks takes one; the walk stops at the null marker.
          want = (cnt == 0) ? 1 : cnt;
          cur = top_ptr;
          taken = 1;
          while (taken < want) begin
            nxt = follow(cur);
            if (nxt >= NULL_MARK) break;
            cur = nxt;
            taken++;
          end
          r.first_out = top_ptr[BLK_W-1:0];
          top_ptr = follow(cur);
          next_of[cur[BLK_W-1:0]] = NULL_MARK;
          r.last_out = cur[BLK_W-1:0];
          r.moved = taken[CNT_W-1:0];
          shrink_total(taken);
        end
      end
    endcase
    r.free_count = free_total;
    r.list_empty = (top_ptr >= NULL_MARK);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Predict on every accepted request, compare on every accepted result item.
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst_n) begin
      top_ptr = NULL_MARK;
      free_total = '0;
      list_replies.delete();
      errors = 0;
    end else begin
      if (req.valid && req.ready)
        list_replies.push_back(apply_list_op(req.opcode, req.block, req.last_block, req.count));
      if (rsp.valid && rsp.ready) begin
        if (list_replies.size() == 0) begin
          $error("result item arrived with no request outstanding");
          errors++;
        end else begin
          want = list_replies.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("first_out", want.first_out, rsp.first_out);
          check_field("last_out", want.last_out, rsp.last_out);
          check_field("moved", want.moved, rsp.moved);
          check_field("free_count", want.free_count, rsp.free_count);
          check_field("list_empty", want.list_empty, rsp.list_empty);
        end
      end
    end
    replies_owed = list_replies.size();
  end

endmodule

// ===== tb/linked_free_list_manager_tb.sv =====
`timescale 1ns / 100ps

module linked_free_list_manager_tb;
  import lflm_pkg::*;

  localparam int unsigned RANDOM_REQS  = 1930;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [BLK_W-1:0] head;
    logic [BLK_W-1:0] tail;
    logic [CNT_W-1:0] length;
  } chain_t;

  logic        clk;
  logic        rst_n;
  int unsigned check_errors;
  int unsigned replies_owed;

  // Blocks and chains handed back by pops, reused for well-formed pushes.
  logic [BLK_W-1:0] returned_blocks [$];
  chain_t           returned_chains [$];

  // Link entries written so far; an arbitrary push range starts at one of these or at its own last block.
  bit               link_written [NUM_BLOCKS_DEF];
  logic [BLK_W-1:0] written_blocks [$];

  bit          calm_tx;
  int unsigned results_seen;

  lflm_req_if in_ch ();
  lflm_rsp_if out_ch ();

  linked_free_list_manager #(.NUM_BLOCKS(NUM_BLOCKS_DEF)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lflm_checker #(.NUM_BLOCKS(NUM_BLOCKS_DEF)) list_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (in_ch),
    .rsp          (out_ch),
    .errors       (check_errors),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void note_link_write(logic [BLK_W-1:0] idx);
    if (!link_written[idx]) begin
      link_written[idx] = 1'b1;
      written_blocks.push_back(idx);
    end
  endfunction

  // Offers one request, with random gaps before it unless calm_tx is set, and waits until it is taken.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                          input logic [BLK_W-1:0] last, input logic [CNT_W-1:0] cnt);
    while (!calm_tx && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.block      <= blk;
    in_ch.last_block <= last;
    in_ch.count      <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_PUSH) note_link_write(blk);
    else if (op == OP_PUSH_RANGE) note_link_write(last);
  endtask

  // Result side: random stalls, one long hold-off, and a stretch with no stalls.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (!out_ch.status && out_ch.moved == 1)
          returned_blocks.push_back(out_ch.first_out);
        else if (!out_ch.status && out_ch.moved > 1)
          returned_chains.push_back('{out_ch.first_out, out_ch.last_out, out_ch.moved});
      end
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (results_seen >= 1000 && results_seen < 1300)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("linked_free_list_manager_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] last;
    logic [CNT_W-1:0] cnt;
    chain_t           chain;
    int unsigned      pick;
    int unsigned      sel;
    int unsigned      fresh_next;
    calm_tx = 1'b0;
    fresh_next = 0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_PUSH;
    in_ch.block      <= '0;
    in_ch.last_block <= '0;
    in_ch.count      <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: both pops report empty, pop range for zero included.
    send_req(OP_POP, 0, 0, 0);
    send_req(OP_POP_RANGE, 0, 0, 0);
    // Extreme block indices in and out again, then empty once more.
    send_req(OP_PUSH, 0, 0, 0);
    send_req(OP_PUSH, 1023, 1023, 1024);
    send_req(OP_POP, 0, 0, 0);
    send_req(OP_POP, 0, 0, 0);
    send_req(OP_POP_RANGE, 0, 0, 5);
    // Build 7 -> 682 -> 341, take one for a zero request, then the last two.
    send_req(OP_PUSH, 341, 0, 0);
    send_req(OP_PUSH, 682, 0, 0);
    send_req(OP_PUSH, 7, 0, 0);
    send_req(OP_POP_RANGE, 0, 0, 0);
    send_req(OP_POP_RANGE, 0, 0, 2);
    // Return the chain, add one block as a range of zero, then drain everything
    // with a count below the walk so the free count floors at zero.
    send_req(OP_PUSH_RANGE, 682, 341, 2);
    send_req(OP_PUSH_RANGE, 7, 7, 0);
    send_req(OP_POP_RANGE, 0, 0, 1024);
    // Saturate the free count, then make a block link to itself.
    send_req(OP_PUSH_RANGE, 7, 7, 1024);
    send_req(OP_PUSH, 1, 0, 0);
    send_req(OP_PUSH_RANGE, 1, 1, 1024);
    // The walk around the self-loop stops after the full count.
    send_req(OP_POP_RANGE, 0, 0, 1024);
    send_req(OP_POP, 0, 0, 0);

    // Random part: mostly recycled blocks and chains, some arbitrary requests.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm_tx = (i >= 1000 && i < 1300);
      pick = $urandom_range(0, 99);
      blk  = BLK_W'($urandom_range(0, 1023));
      last = BLK_W'($urandom_range(0, 1023));
      cnt  = CNT_W'($urandom_range(0, 1024));
      if (pick < 30) begin
        op = OP_PUSH;
        if ($urandom_range(0, 9) != 0) begin
          if (returned_blocks.size() != 0) begin
            blk = returned_blocks.pop_front();
          end else if (fresh_next < NUM_BLOCKS_DEF) begin
            blk = BLK_W'(fresh_next);
            fresh_next++;
          end
        end
      end else if (pick < 55) begin
        op = OP_POP;
      end else if (pick < 75) begin
        op = OP_PUSH_RANGE;
        if (returned_chains.size() != 0 && $urandom_range(0, 4) != 0) begin
          chain = returned_chains.pop_front();
          blk  = chain.head;
          last = chain.tail;
          cnt  = chain.length;
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 10) cnt = 0;
          else if (sel < 15) cnt = 1024;
          else if (sel < 90) cnt = CNT_W'($urandom_range(0, 32));
          if (written_blocks.size() == 0 || $urandom_range(0, 3) == 0)
            blk = last;
          else
            blk = written_blocks[$urandom_range(0, written_blocks.size() - 1)];
        end
      end else begin
        op = OP_POP_RANGE;
        sel = $urandom_range(0, 99);
        if (sel < 10) cnt = 0;
        else if (sel >= 15) cnt = CNT_W'($urandom_range(1, 16));
      end
      send_req(op, blk, last, cnt);
    end
    in_ch.valid <= 1'b0;

    // Let every owed result item come back, then watch for strays.
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_errors == 0 && replies_owed == 0)
      $display("linked_free_list_manager_tb: clean");
    else
      $display("linked_free_list_manager_tb: errors");
    $finish;
  end

endmodule
